// ----- design/average_pooling_window_core_assert.svh -----
// Assertion macros for the average pooling window core checker.
`ifndef AVERAGE_POOLING_WINDOW_CORE_ASSERT_SVH
`define AVERAGE_POOLING_WINDOW_CORE_ASSERT_SVH

// Next-cycle implication, held off while in reset.
`define APW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("apw: next-cycle check failed");

// Next-cycle implication that is also checked during reset.
`define APW_ASSERT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("apw: check failed");

`endif

// ----- design/apw_pkg.sv -----
// Shared constants, types and codes of the average pooling window core.
package apw_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_WINDOW  = 5;
  localparam int PIXEL_BITS  = 16;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int SUM_W       = 21;
  localparam int DEN_W       = 5;
  localparam int DCNT_W      = $clog2(SUM_W);
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int WIDTH_W     = 9;
  localparam int HEIGHT_W    = 11;
  localparam int WIN_W       = 3;
  localparam int STEP_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 4'd3;

  // reset values
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 9'd64;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 11'd64;
  localparam logic [WIN_W-1:0]    RST_WINDOW = 3'd2;
  localparam logic [STEP_W-1:0]   RST_STEP   = 4'd2;

  // read token handed down the cell chain
  typedef struct packed {
    logic                  vld;
    logic [COL_W-1:0]      col;
    logic [MAX_WINDOW-1:0] mask;
  } tok_t;

  // partial column sum handed down the cell chain
  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] val;
  } sum_t;

  // divider result
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quo;
    logic [DEN_W-1:0] rem;
  } div_res_t;

endpackage

// ----- design/apw_pix_if.sv -----
// Input pixel channel.
interface apw_pix_if;
  import apw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ----- design/apw_res_if.sv -----
// Result channel.
interface apw_res_if;
  import apw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] average_value;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_column;
  logic                  frame_last;
  modport source (output valid, output average_value, output out_row, output out_column,
                  output frame_last, input ready);
  modport sink (input valid, input average_value, input out_row, input out_column,
                input frame_last, output ready);
endinterface

// ----- design/apw_cfg_if.sv -----
// Register write channel.
interface apw_cfg_if;
  import apw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output addr, output data, input ready);
  modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- design/apw_cell.sv -----
// One row slot of the line store plus its stage of the column-sum chain.
module apw_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [apw_pkg::COL_W-1:0]      wr_col,
  input  logic [apw_pkg::PIXEL_BITS-1:0] wr_data,
  input  apw_pkg::tok_t                  tok_in,
  output apw_pkg::tok_t                  tok_out,
  input  apw_pkg::sum_t                  sum_in,
  output apw_pkg::sum_t                  sum_out
);
  import apw_pkg::*;

  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  use_r;
  logic                  vld_r;
  tok_t                  tok_r;
  sum_t                  sum_r;

  // row memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_col] <= wr_data;
    end
    rd_data_r <= mem[tok_in.col];
  end

  // token moves on, mask shifted so the next cell sees its own bit at the bottom
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      use_r <= 1'b0;
      vld_r <= 1'b0;
      sum_r <= '0;
    end else begin
      tok_r.vld  <= tok_in.vld;
      tok_r.col  <= tok_in.col;
      tok_r.mask <= tok_in.mask >> 1;
      use_r      <= tok_in.vld & tok_in.mask[0];
      vld_r      <= tok_in.vld;
      sum_r.vld  <= vld_r;
      sum_r.val  <= sum_in.val + (use_r ? {{(SUM_W-PIXEL_BITS){1'b0}}, rd_data_r} : '0);
    end
  end

  assign tok_out = tok_r;
  assign sum_out = sum_r;
endmodule

// ----- design/apw_div.sv -----
// Restoring divider, one quotient bit per cycle.
module apw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [apw_pkg::SUM_W-1:0] num,
  input  logic [apw_pkg::DEN_W-1:0] den,
  output apw_pkg::div_res_t         res
);
  import apw_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]  quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [DEN_W:0]    diff;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem_r, quo_r[SUM_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(SUM_W - 1);
        quo_r  <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        quo_r <= {quo_r[SUM_W-2:0], qbit};
        rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r;
endmodule

// ----- design/average_pooling_window_core.sv -----
// Top level of the strided average pooling window core.
// Usage:
//  - in_ch carries one 16-bit pixel per word in raster order; a word is taken
//    when valid and ready are both high. out_ch carries one rounded window
//    average with its output row, column and a frame_last flag.
//  - cfg_ch writes image_width (0), image_height (1), window_size (2) and
//    step_size (3); it is always ready. Write only while the core is idle.
//  - A pixel that completes no window goes back to idle after the check; one
//    whose window fails the row or column stride check goes back after that
//    division. For a pixel that yields a result the shared one-bit-per-cycle
//    divider runs five divisions (row and column grid, the average by k*k,
//    the output frame height and width), and the k window columns stream
//    through the chain of five row cells.
//  - The result sits in an output register; the next pixel is taken while it
//    waits. If the receiver stalls, a finished result waits in the core until
//    the register frees up.
//  - Synchronous reset clears the row and column counters, the output valid
//    and sets the registers to 64, 64, 2, 2. The line store is not cleared.
module average_pooling_window_core (
  input logic        clk,
  input logic        rst_n,
  apw_pix_if.sink    in_ch,
  apw_res_if.source  out_ch,
  apw_cfg_if.sink    cfg_ch
);
  import apw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_DIVR, S_DIVC, S_SUM, S_WAIT, S_DIVA, S_DIVH, S_DIVW, S_OUT
  } state_t;

  state_t                state_r;
  logic [WIDTH_W-1:0]    width_r;
  logic [HEIGHT_W-1:0]   height_r;
  logic [WIN_W-1:0]      win_r;
  logic [STEP_W-1:0]     step_r;
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_r;
  logic [SLOT_W-1:0]     slot_r;

  // per-item copies
  logic [ROW_W-1:0]      rq_r;
  logic [COL_W-1:0]      cq_r;
  logic [SLOT_W-1:0]     sq_r;
  logic [WIDTH_W-1:0]    wq_r;
  logic [HEIGHT_W-1:0]   hq_r;
  logic [WIN_W-1:0]      kq_r;
  logic [STEP_W-1:0]     stq_r;
  logic [COL_W-1:0]      c0_r;
  logic [MAX_WINDOW-1:0] mask_r;
  logic [WIN_W-1:0]      j_r;
  logic [WIN_W-1:0]      rcv_r;
  logic [SUM_W-1:0]      acc_r;
  logic [ROW_W-1:0]      orow_r;
  logic [COL_W-1:0]      ocol_r;
  logic [ROW_W-1:0]      qh_r;
  logic [PIXEL_BITS-1:0] avg_r;
  logic                  last_r;
  tok_t                  tok_r;
  logic                  dstart_r;
  logic [SUM_W-1:0]      dnum_r;
  logic [DEN_W-1:0]      dden_r;
  div_res_t              dres;

  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_avg_r;
  logic [ROW_W-1:0]      out_row_r;
  logic [COL_W-1:0]      out_col_r;
  logic                  out_last_r;

  logic                  in_acc;
  logic [WIDTH_W-1:0]    w_cl;
  logic [HEIGHT_W-1:0]   h_cl;
  logic [WIN_W-1:0]      k_cl;
  logic [STEP_W-1:0]     s_cl;
  logic                  cond;
  logic [ROW_W-1:0]      r0;
  logic [COL_W-1:0]      c0;
  logic [MAX_WINDOW-1:0] mask;
  logic [SLOT_W:0]       base_t;
  logic [SLOT_W-1:0]     base0;
  logic [SLOT_W:0]       d;
  logic [DEN_W-1:0]      kk;
  logic [2*WIN_W-1:0]    kk_full;
  logic                  round_up;

  tok_t                  tok_w [MAX_WINDOW+1];
  sum_t                  sum_w [MAX_WINDOW+1];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // register bounds as the datapath uses them
  always_comb begin
    w_cl = (width_r == '0) ? WIDTH_W'(1) :
           (width_r > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_r;
    h_cl = (height_r == '0) ? HEIGHT_W'(1) :
           (height_r > HEIGHT_W'(MAX_HEIGHT)) ? HEIGHT_W'(MAX_HEIGHT) : height_r;
    k_cl = (win_r == '0) ? WIN_W'(1) :
           (win_r > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : win_r;
    s_cl = (step_r == '0) ? STEP_W'(1) : step_r;
  end

  // window check, origin and row-slot mask for the held pixel
  always_comb begin
    cond = ({1'b0, rq_r} + 1'b1 >= HEIGHT_W'(kq_r)) &&
           ({1'b0, cq_r} + 1'b1 >= WIDTH_W'(kq_r)) &&
           (WIDTH_W'(kq_r) <= wq_r) && (HEIGHT_W'(kq_r) <= hq_r);
    r0 = rq_r + 1'b1 - ROW_W'(kq_r);
    c0 = cq_r + 1'b1 - COL_W'(kq_r);
    base_t = {1'b0, sq_r} + (SLOT_W+1)'(MAX_WINDOW) - (SLOT_W+1)'(kq_r - 1'b1);
    base0 = (base_t >= (SLOT_W+1)'(MAX_WINDOW)) ?
            SLOT_W'(base_t - (SLOT_W+1)'(MAX_WINDOW)) : SLOT_W'(base_t);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      d = (SLOT_W+1)'(i) + (SLOT_W+1)'(MAX_WINDOW) - {1'b0, base0};
      if (d >= (SLOT_W+1)'(MAX_WINDOW)) begin
        d = d - (SLOT_W+1)'(MAX_WINDOW);
      end
      mask[i] = ({1'b0, d} < (SLOT_W+2)'(kq_r));
    end
    kk_full  = {{WIN_W{1'b0}}, kq_r} * {{WIN_W{1'b0}}, kq_r};
    kk       = kk_full[DEN_W-1:0];
    round_up = ({dres.rem, 1'b0} >= {1'b0, kk});
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      win_r    <= RST_WINDOW;
      step_r   <= RST_STEP;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_ch.data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_ch.data[HEIGHT_W-1:0];
        REG_WINDOW_SIZE:  win_r    <= cfg_ch.data[WIN_W-1:0];
        REG_STEP_SIZE:    step_r   <= cfg_ch.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      slot_r      <= '0;
      tok_r       <= '0;
      dstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rcv_r       <= '0;
      j_r         <= '0;
    end else begin
      // divider start pulses and chain token valid
      dstart_r  <= ((state_r == S_CHK) && cond) ||
                   ((state_r == S_DIVR) && dres.done && (dres.rem == '0)) ||
                   ((state_r == S_WAIT) && sum_w[MAX_WINDOW].vld &&
                    (rcv_r == kq_r - 1'b1)) ||
                   (((state_r == S_DIVA) || (state_r == S_DIVH)) && dres.done);
      tok_r.vld <= (state_r == S_SUM);
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rq_r  <= row_r;
            cq_r  <= col_r;
            sq_r  <= slot_r;
            wq_r  <= w_cl;
            hq_r  <= h_cl;
            kq_r  <= k_cl;
            stq_r <= s_cl;
            // advance raster position
            if ({1'b0, col_r} + 1'b1 >= w_cl) begin
              col_r <= '0;
              if ({1'b0, row_r} + 1'b1 >= h_cl) begin
                row_r  <= '0;
                slot_r <= '0;
              end else begin
                row_r  <= row_r + 1'b1;
                slot_r <= (slot_r == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_r + 1'b1;
              end
            end else begin
              col_r <= col_r + 1'b1;
            end
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (cond) begin
            c0_r     <= c0;
            mask_r   <= mask;
            dnum_r   <= SUM_W'(r0);
            dden_r   <= DEN_W'(stq_r);
            state_r  <= S_DIVR;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIVR: begin
          if (dres.done) begin
            if (dres.rem != '0) begin
              state_r <= S_IDLE;
            end else begin
              orow_r   <= dres.quo[ROW_W-1:0];
              dnum_r   <= SUM_W'(c0_r);
              state_r  <= S_DIVC;
            end
          end
        end
        S_DIVC: begin
          if (dres.done) begin
            if (dres.rem != '0) begin
              state_r <= S_IDLE;
            end else begin
              ocol_r  <= dres.quo[COL_W-1:0];
              j_r     <= '0;
              rcv_r   <= '0;
              acc_r   <= '0;
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // one window column per cycle into the chain
          tok_r.col  <= c0_r + COL_W'(j_r);
          tok_r.mask <= mask_r;
          j_r        <= j_r + 1'b1;
          if (j_r == kq_r - 1'b1) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (sum_w[MAX_WINDOW].vld) begin
            acc_r <= acc_r + sum_w[MAX_WINDOW].val;
            rcv_r <= rcv_r + 1'b1;
            if (rcv_r == kq_r - 1'b1) begin
              dnum_r   <= acc_r + sum_w[MAX_WINDOW].val;
              dden_r   <= kk;
              state_r  <= S_DIVA;
            end
          end
        end
        S_DIVA: begin
          if (dres.done) begin
            avg_r    <= dres.quo[PIXEL_BITS-1:0] + PIXEL_BITS'(round_up);
            dnum_r   <= SUM_W'(hq_r - HEIGHT_W'(kq_r));
            dden_r   <= DEN_W'(stq_r);
            state_r  <= S_DIVH;
          end
        end
        S_DIVH: begin
          if (dres.done) begin
            qh_r     <= dres.quo[ROW_W-1:0];
            dnum_r   <= SUM_W'(wq_r - WIDTH_W'(kq_r));
            state_r  <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (dres.done) begin
            last_r  <= (orow_r == qh_r) && (ocol_r == dres.quo[COL_W-1:0]);
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= avg_r;
            out_row_r   <= orow_r;
            out_col_r   <= ocol_r;
            out_last_r  <= last_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // chain of row cells
  assign tok_w[0] = tok_r;
  assign sum_w[0] = '0;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    apw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (in_acc && (slot_r == SLOT_W'(g))),
      .wr_col  (col_r),
      .wr_data (in_ch.pixel_value),
      .tok_in  (tok_w[g]),
      .tok_out (tok_w[g+1]),
      .sum_in  (sum_w[g]),
      .sum_out (sum_w[g+1])
    );
  end

  apw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dstart_r),
    .num   (dnum_r),
    .den   (dden_r),
    .res   (dres)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.average_value = out_avg_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_column    = out_col_r;
  assign out_ch.frame_last    = out_last_r;
endmodule

// ----- design/apw_checker.sv -----
// Port-level checker for the average pooling window core, bound to the top.
`include "average_pooling_window_core_assert.svh"

module apw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // a result stays offered until taken
  `APW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one pixel at a time: ready drops after a word is taken
  `APW_ASSERT_NEXT(a_in_one_word, clk, rst_n, in_valid && in_ready, !in_ready)

  // reset empties the output register
  `APW_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind average_pooling_window_core apw_checker u_apw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
